[hw/rtl/lcv_pkg.sv]
// Shared types and constants of the LRU cache with victim store.
package lcv_pkg;

   localparam int KEY_W         = 256;
   localparam int WORD_W        = 64;
   localparam int DATA_W        = 64;
   localparam int ENTRY_W       = KEY_W + DATA_W;
   localparam int CMD_W         = 3;
   localparam int LIMIT_W       = 5;
   localparam int LRU_COUNT_W   = 5;
   localparam int DIRTY_COUNT_W = 6;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd5;

   localparam logic             CSR_IDX_LIMIT = 1'b0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VSCAN,
      ST_RSCAN,
      ST_ANEW,
      ST_ANEW_WR,
      ST_EVCHK,
      ST_EV_RD,
      ST_EV_WR,
      ST_FLUSH_V,
      ST_FLUSH_VE,
      ST_FLUSH_R,
      ST_FLUSH_RE,
      ST_RESP
   } state_type;

endpackage

[hw/rtl/lcv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lcv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lru_cache_with_victim_store.sv]
// LRU key/payload cache with a bounded victim store, run by one scanning sequencer.
// Add/get/remove/contains time is set by the one-entry-per-cycle key compare over both stores
// and, for add, up to two evictions (one for get); flush scans every victim slot, then the
// recency entries, and output stalls hold it.
// Throughput: one item at a time; ready only when the sequencer is idle.
// Reset (synchronous): both stores empty, lru_limit = 16, no result pending.
module lru_cache_with_victim_store
   import lcv_pkg::*;
#(
   parameter int LRU_DEPTH   = 16,
   parameter int DIRTY_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [WORD_W-1:0]        req_key_w0,
   input  logic [WORD_W-1:0]        req_key_w1,
   input  logic [WORD_W-1:0]        req_key_w2,
   input  logic [WORD_W-1:0]        req_key_w3,
   input  logic [DATA_W-1:0]        req_entry_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [DATA_W-1:0]        rsp_out_data,
   output logic [WORD_W-1:0]        rsp_out_key_w0,
   output logic [WORD_W-1:0]        rsp_out_key_w1,
   output logic [WORD_W-1:0]        rsp_out_key_w2,
   output logic [WORD_W-1:0]        rsp_out_key_w3,
   output logic                     rsp_from_dirty,
   output logic                     rsp_last,
   output logic [LRU_COUNT_W-1:0]   rsp_lru_count,
   output logic [DIRTY_COUNT_W-1:0] rsp_dirty_count,
   output logic                     rsp_dropped,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   localparam int RAW  = (LRU_DEPTH > 1) ? $clog2(LRU_DEPTH) : 1;
   localparam int VAW  = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
   localparam int RCW  = $clog2(LRU_DEPTH + 1);
   localparam int VCW  = $clog2(DIRTY_DEPTH + 1);
   localparam int MAXD = (LRU_DEPTH > DIRTY_DEPTH) ? LRU_DEPTH : DIRTY_DEPTH;
   localparam int SW   = $clog2(MAXD + 1);
   localparam int AGW  = RAW;
   localparam int LW   = (RCW > LIMIT_W) ? RCW : LIMIT_W;
   localparam int LW1  = LW + 1;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic [LRU_DEPTH-1:0]   rvalid_ff, rvalid_in;
   logic [AGW-1:0]         age_ff [LRU_DEPTH];
   logic [AGW-1:0]         age_in [LRU_DEPTH];
   logic [DIRTY_DEPTH-1:0] vvalid_ff, vvalid_in;
   logic [RCW-1:0]         rcnt_ff, rcnt_in;
   logic [VCW-1:0]         vcnt_ff, vcnt_in;
   logic [SW-1:0]          sidx_ff, sidx_in;
   logic [RCW-1:0]         fa_ff, fa_in;
   logic                   lost_ff, lost_in;
   logic                   res_hit_ff, res_hit_in;
   logic [DATA_W-1:0]      res_data_ff, res_data_in;
   logic [RAW-1:0]         ev_slot_ff, ev_slot_in;
   logic                   emitted_ff, emitted_in;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     o_hit_ff, o_hit_in;
   logic [DATA_W-1:0]        o_data_ff, o_data_in;
   logic [KEY_W-1:0]         o_key_ff, o_key_in;
   logic                     o_dirty_ff, o_dirty_in;
   logic                     o_last_ff, o_last_in;
   logic [LRU_COUNT_W-1:0]   o_lc_ff, o_lc_in;
   logic [DIRTY_COUNT_W-1:0] o_dc_ff, o_dc_in;
   logic                     o_drop_ff, o_drop_in;
   logic                     ld_out, out_free;

   logic               r_we, v_we;
   logic [RAW-1:0]     r_waddr, r_raddr;
   logic [VAW-1:0]     v_waddr, v_raddr;
   logic [ENTRY_W-1:0] r_wdata, r_rdata, v_wdata, v_rdata;

   logic [RAW-1:0] jr, free_r_idx, old_idx, fa_idx;
   logic [VAW-1:0] jv, free_v_idx, sv;
   logic           rhit, rdone, vhit, vdone;
   logic           free_r_ok, free_v_ok, old_ok;
   logic [LW-1:0]  lim_x, lim_eff;
   logic           over0, over1;
   logic [DIRTY_DEPTH-1:0] vsel;

   logic [RCW+LRU_COUNT_W-1:0]   lc_wide;
   logic [VCW+DIRTY_COUNT_W-1:0] dc_wide;

   lcv_ram #(.WIDTH(ENTRY_W), .DEPTH(LRU_DEPTH)) u_recent_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   lcv_ram #(.WIDTH(ENTRY_W), .DEPTH(DIRTY_DEPTH)) u_victim_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == CSR_IDX_LIMIT) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   // effective limit and overflow checks
   always_comb begin
      lim_x = LW'(limit_ff);
      if (lim_x == '0) begin
         lim_eff = LW'(1);
      end else if (lim_x > LW'(LRU_DEPTH)) begin
         lim_eff = LW'(LRU_DEPTH);
      end else begin
         lim_eff = lim_x;
      end
      over0 = LW1'(rcnt_ff) > LW1'(lim_eff);
      over1 = (LW1'(rcnt_ff) + LW1'(1)) > LW1'(lim_eff);
   end

   // scan compare, one entry per cycle behind the RAM read
   always_comb begin
      jr    = RAW'(sidx_ff - SW'(1));
      jv    = VAW'(sidx_ff - SW'(1));
      rhit  = (sidx_ff != '0) && rvalid_ff[jr] && (r_rdata[KEY_W-1:0] == key_ff);
      vhit  = (sidx_ff != '0) && vvalid_ff[jv] && (v_rdata[KEY_W-1:0] == key_ff);
      rdone = rhit || (sidx_ff == SW'(LRU_DEPTH));
      vdone = vhit || (sidx_ff == SW'(DIRTY_DEPTH));
      sv    = sidx_ff[VAW-1:0];
      vsel  = DIRTY_DEPTH'(1) << sv;
   end

   // slot encoders over the valid and age flops
   always_comb begin
      free_r_idx = '0;
      free_r_ok  = 1'b0;
      old_idx    = '0;
      old_ok     = 1'b0;
      fa_idx     = '0;
      for (int i = LRU_DEPTH - 1; i >= 0; i--) begin
         if (!rvalid_ff[i]) begin
            free_r_idx = RAW'(i);
            free_r_ok  = 1'b1;
         end
         if (rvalid_ff[i] && RCW'(age_ff[i]) == rcnt_ff - RCW'(1)) begin
            old_idx = RAW'(i);
            old_ok  = 1'b1;
         end
         if (rvalid_ff[i] && RCW'(age_ff[i]) == fa_ff) begin
            fa_idx = RAW'(i);
         end
      end
      free_v_idx = '0;
      free_v_ok  = 1'b0;
      for (int i = DIRTY_DEPTH - 1; i >= 0; i--) begin
         if (!vvalid_ff[i]) begin
            free_v_idx = VAW'(i);
            free_v_ok  = 1'b1;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      data_in     = data_ff;
      rvalid_in   = rvalid_ff;
      vvalid_in   = vvalid_ff;
      for (int i = 0; i < LRU_DEPTH; i++) begin
         age_in[i] = age_ff[i];
      end
      rcnt_in     = rcnt_ff;
      vcnt_in     = vcnt_ff;
      sidx_in     = sidx_ff;
      fa_in       = fa_ff;
      lost_in     = lost_ff;
      res_hit_in  = res_hit_ff;
      res_data_in = res_data_ff;
      ev_slot_in  = ev_slot_ff;
      emitted_in  = emitted_ff;

      r_we    = 1'b0;
      r_waddr = '0;
      r_wdata = {data_ff, key_ff};
      r_raddr = sidx_ff[RAW-1:0];
      v_we    = 1'b0;
      v_waddr = '0;
      v_wdata = r_rdata;
      v_raddr = sv;

      ld_out     = 1'b0;
      o_hit_in   = 1'b0;
      o_data_in  = '0;
      o_key_in   = '0;
      o_dirty_in = 1'b0;
      o_last_in  = 1'b0;
      req_ready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in      = req_cmd;
               key_in      = {req_key_w3, req_key_w2, req_key_w1, req_key_w0};
               data_in     = req_entry_data;
               lost_in     = 1'b0;
               sidx_in     = '0;
               res_hit_in  = 1'b0;
               res_data_in = '0;
               emitted_in  = 1'b0;
               case (req_cmd)
                  CMD_ADD, CMD_GET: begin
                     state_in = ST_VSCAN;
                  end
                  CMD_REMOVE, CMD_CONTAINS: begin
                     state_in = ST_RSCAN;
                  end
                  CMD_CLEAR: begin
                     rvalid_in = '0;
                     vvalid_in = '0;
                     for (int i = 0; i < LRU_DEPTH; i++) begin
                        age_in[i] = '0;
                     end
                     rcnt_in  = '0;
                     vcnt_in  = '0;
                     state_in = ST_RESP;
                  end
                  CMD_FLUSH: begin
                     vcnt_in  = '0;
                     fa_in    = '0;
                     state_in = ST_FLUSH_V;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_VSCAN: begin
            if (!vdone) begin
               sidx_in = sidx_ff + SW'(1);
            end else begin
               if (vhit && cmd_ff != CMD_CONTAINS) begin
                  vvalid_in[jv] = 1'b0;
                  vcnt_in       = vcnt_ff - VCW'(1);
               end
               case (cmd_ff)
                  CMD_GET: begin
                     if (vhit) begin
                        data_in  = v_rdata[ENTRY_W-1:KEY_W];
                        state_in = ST_ANEW;
                     end else begin
                        sidx_in  = '0;
                        state_in = ST_RSCAN;
                     end
                  end
                  CMD_ADD: begin
                     sidx_in  = '0;
                     state_in = ST_RSCAN;
                  end
                  CMD_CONTAINS: begin
                     res_hit_in = vhit;
                     state_in   = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_RSCAN: begin
            if (!rdone) begin
               sidx_in = sidx_ff + SW'(1);
            end else begin
               case (cmd_ff)
                  CMD_ADD, CMD_GET: begin
                     if (rhit) begin
                        for (int i = 0; i < LRU_DEPTH; i++) begin
                           if (rvalid_ff[i] && age_ff[i] < age_ff[jr]) begin
                              age_in[i] = age_ff[i] + AGW'(1);
                           end
                        end
                        age_in[jr] = '0;
                     end
                     if (cmd_ff == CMD_ADD) begin
                        if (rhit) begin
                           r_we     = 1'b1;
                           r_waddr  = jr;
                           state_in = ST_EVCHK;
                        end else begin
                           state_in = ST_ANEW;
                        end
                     end else begin
                        res_hit_in  = rhit;
                        res_data_in = rhit ? r_rdata[ENTRY_W-1:KEY_W] : '0;
                        state_in    = ST_RESP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rhit) begin
                        for (int i = 0; i < LRU_DEPTH; i++) begin
                           if (rvalid_ff[i] && age_ff[i] > age_ff[jr]) begin
                              age_in[i] = age_ff[i] - AGW'(1);
                           end
                        end
                        rvalid_in[jr] = 1'b0;
                        age_in[jr]    = '0;
                        rcnt_in       = rcnt_ff - RCW'(1);
                     end
                     sidx_in  = '0;
                     state_in = ST_VSCAN;
                  end
                  default: begin
                     if (rhit) begin
                        res_hit_in = 1'b1;
                        state_in   = ST_RESP;
                     end else begin
                        sidx_in  = '0;
                        state_in = ST_VSCAN;
                     end
                  end
               endcase
            end
         end

         ST_ANEW: begin
            if (over1) begin
               ret_in   = ST_ANEW_WR;
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_ANEW_WR;
            end
         end

         ST_ANEW_WR: begin
            if (free_r_ok) begin
               for (int i = 0; i < LRU_DEPTH; i++) begin
                  if (rvalid_ff[i]) begin
                     age_in[i] = age_ff[i] + AGW'(1);
                  end
               end
               r_we                  = 1'b1;
               r_waddr               = free_r_idx;
               rvalid_in[free_r_idx] = 1'b1;
               age_in[free_r_idx]    = '0;
               rcnt_in               = rcnt_ff + RCW'(1);
            end
            if (cmd_ff == CMD_GET) begin
               res_hit_in  = 1'b1;
               res_data_in = data_ff;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_EVCHK;
            end
         end

         ST_EVCHK: begin
            if (over0) begin
               ret_in   = ST_RESP;
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_EV_RD: begin
            if (old_ok && rcnt_ff != '0) begin
               r_raddr    = old_idx;
               ev_slot_in = old_idx;
               state_in   = ST_EV_WR;
            end else begin
               state_in = ret_ff;
            end
         end

         ST_EV_WR: begin
            if (free_v_ok) begin
               v_we                  = 1'b1;
               v_waddr               = free_v_idx;
               vvalid_in[free_v_idx] = 1'b1;
               vcnt_in               = vcnt_ff + VCW'(1);
            end else begin
               lost_in = 1'b1;
            end
            rvalid_in[ev_slot_ff] = 1'b0;
            age_in[ev_slot_ff]    = '0;
            rcnt_in               = rcnt_ff - RCW'(1);
            state_in              = ret_ff;
         end

         ST_FLUSH_V: begin
            if (sidx_ff == SW'(DIRTY_DEPTH)) begin
               fa_in    = '0;
               state_in = ST_FLUSH_R;
            end else if (vvalid_ff[sv]) begin
               state_in = ST_FLUSH_VE;
            end else begin
               sidx_in = sidx_ff + SW'(1);
            end
         end

         ST_FLUSH_VE: begin
            if (out_free) begin
               ld_out        = 1'b1;
               o_hit_in      = 1'b1;
               o_data_in     = v_rdata[ENTRY_W-1:KEY_W];
               o_key_in      = v_rdata[KEY_W-1:0];
               o_dirty_in    = 1'b1;
               o_last_in     = !(|(vvalid_ff & ~vsel)) && rcnt_ff == '0;
               vvalid_in[sv] = 1'b0;
               emitted_in    = 1'b1;
               sidx_in       = sidx_ff + SW'(1);
               state_in      = ST_FLUSH_V;
            end
         end

         ST_FLUSH_R: begin
            r_raddr = fa_idx;
            if (fa_ff == rcnt_ff) begin
               state_in = emitted_ff ? ST_IDLE : ST_RESP;
            end else begin
               state_in = ST_FLUSH_RE;
            end
         end

         ST_FLUSH_RE: begin
            r_raddr = fa_idx;
            if (out_free) begin
               ld_out     = 1'b1;
               o_hit_in   = 1'b1;
               o_data_in  = r_rdata[ENTRY_W-1:KEY_W];
               o_key_in   = r_rdata[KEY_W-1:0];
               o_last_in  = (fa_ff + RCW'(1)) == rcnt_ff;
               emitted_in = 1'b1;
               fa_in      = fa_ff + RCW'(1);
               state_in   = ST_FLUSH_R;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               ld_out    = 1'b1;
               o_hit_in  = res_hit_ff;
               o_data_in = res_data_ff;
               o_last_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      lc_wide   = {{LRU_COUNT_W{1'b0}}, rcnt_ff};
      dc_wide   = {{DIRTY_COUNT_W{1'b0}}, vcnt_ff};
      o_lc_in   = lc_wide[LRU_COUNT_W-1:0];
      o_dc_in   = dc_wide[DIRTY_COUNT_W-1:0];
      o_drop_in = lost_ff && (cmd_ff != CMD_FLUSH);
      if (ld_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rvalid_ff    <= '0;
         vvalid_ff    <= '0;
         rcnt_ff      <= '0;
         vcnt_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LRU_DEPTH; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rvalid_ff    <= rvalid_in;
         vvalid_ff    <= vvalid_in;
         rcnt_ff      <= rcnt_in;
         vcnt_ff      <= vcnt_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < LRU_DEPTH; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      data_ff     <= data_in;
      sidx_ff     <= sidx_in;
      fa_ff       <= fa_in;
      lost_ff     <= lost_in;
      res_hit_ff  <= res_hit_in;
      res_data_ff <= res_data_in;
      ev_slot_ff  <= ev_slot_in;
      emitted_ff  <= emitted_in;
      if (ld_out) begin
         o_hit_ff   <= o_hit_in;
         o_data_ff  <= o_data_in;
         o_key_ff   <= o_key_in;
         o_dirty_ff <= o_dirty_in;
         o_last_ff  <= o_last_in;
         o_lc_ff    <= o_lc_in;
         o_dc_ff    <= o_dc_in;
         o_drop_ff  <= o_drop_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = o_hit_ff;
   assign rsp_out_data    = o_data_ff;
   assign rsp_out_key_w0  = o_key_ff[WORD_W-1:0];
   assign rsp_out_key_w1  = o_key_ff[2*WORD_W-1:WORD_W];
   assign rsp_out_key_w2  = o_key_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_out_key_w3  = o_key_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_from_dirty  = o_dirty_ff;
   assign rsp_last        = o_last_ff;
   assign rsp_lru_count   = o_lc_ff;
   assign rsp_dirty_count = o_dc_ff;
   assign rsp_dropped     = o_drop_ff;

   a_rcnt_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(rvalid_ff) == int'(rcnt_ff))
      else $error("recency count out of step with valid bits");

   a_vcnt_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(vvalid_ff) == int'(vcnt_ff))
      else $error("victim count out of step with valid bits");

   a_rcnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(rcnt_ff) <= LRU_DEPTH)
      else $error("recency count above depth");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted item did not start the sequencer");

endmodule
